// ----- hdl/assert_macros.svh -----
// assertion macros used by the address map table rtl
// depends on nothing; included by address_map_table_unit, the file that carries concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define AMT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define AMT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/amt_pkg.sv -----
// shared types and codes for the address map table
// depends on nothing; imported by amt_cell, address_map_table_unit, amt_result_check and the testbench
package amt_pkg;

	// operation codes
	localparam logic [1:0] FUNC_ADD      = 2'd0;
	localparam logic [1:0] FUNC_PUB2PRIV = 2'd1;
	localparam logic [1:0] FUNC_PRIV2PUB = 2'd2;
	localparam logic [1:0] FUNC_NONE     = 2'd3;

	// address family codes
	localparam logic [1:0] FAM_IPV4 = 2'd0;
	localparam logic [1:0] FAM_IPV6 = 2'd1;

	typedef struct packed {
		logic [1:0]  func;
		logic [1:0]  key_family;
		logic [63:0] key_addr_hi;
		logic [63:0] key_addr_lo;
		logic [15:0] key_port;
		logic [1:0]  val_family;
		logic [63:0] val_addr_hi;
		logic [63:0] val_addr_lo;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  out_family;
		logic [63:0] out_addr_hi;
		logic [63:0] out_addr_lo;
		logic [15:0] out_port;
		logic        hit;
		logic        table_full;
	} out_item_t;

	// transaction token walking down the cell row
	typedef struct packed {
		logic        vld;
		in_item_t    item;
		logic        found;
		logic [1:0]  res_family;
		logic [63:0] res_addr_hi;
		logic [63:0] res_addr_lo;
	} token_t;

endpackage

// ----- hdl/amt_cell.sv -----
// one table entry of the address map table and its compare logic
// depends on amt_pkg; chained by address_map_table_unit
module amt_cell import amt_pkg::*; #(
	parameter int CNT_W = 5,
	parameter int INDEX = 0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [CNT_W-1:0] count,
	input  token_t           tok_in,
	output token_t           tok_out
);

	logic [1:0]  pub_family_q;
	logic [63:0] pub_addr_hi_q;
	logic [63:0] pub_addr_lo_q;
	logic [1:0]  priv_family_q;
	logic [63:0] priv_addr_hi_q;
	logic [63:0] priv_addr_lo_q;
	token_t      tok_q;
	logic        tok_vld_q;
	token_t      tok_nxt;
	logic        occupied;
	logic        write_en;
	logic        pub_match;
	logic        priv_match;

	// family must agree and be ipv4 or ipv6; ipv4 looks at the low 32 bits only
	function automatic logic same_addr(input logic [1:0] fam, input logic [63:0] hi,
		input logic [63:0] lo, input logic [1:0] sfam, input logic [63:0] shi,
		input logic [63:0] slo);
		logic r;
		r = 1'b0;
		if (fam == sfam) begin
			if (fam == FAM_IPV4)
				r = (lo[31:0] == slo[31:0]);
			else if (fam == FAM_IPV6)
				r = (hi == shi) && (lo == slo);
		end
		return r;
	endfunction

	assign occupied = (CNT_W'(INDEX) < count);
	assign write_en = tok_in.vld && (tok_in.item.func == FUNC_ADD) &&
		(count == CNT_W'(INDEX));

	assign pub_match = same_addr(tok_in.item.key_family, tok_in.item.key_addr_hi,
		tok_in.item.key_addr_lo, pub_family_q, pub_addr_hi_q, pub_addr_lo_q);
	assign priv_match = same_addr(tok_in.item.key_family, tok_in.item.key_addr_hi,
		tok_in.item.key_addr_lo, priv_family_q, priv_addr_hi_q, priv_addr_lo_q);

	// first match along the row wins; later cells pass it through
	always_comb begin
		tok_nxt = tok_in;
		if (tok_in.vld && occupied && !tok_in.found) begin
			case (tok_in.item.func)
				FUNC_PUB2PRIV: begin
					if (pub_match) begin
						tok_nxt.found       = 1'b1;
						tok_nxt.res_family  = priv_family_q;
						tok_nxt.res_addr_hi = priv_addr_hi_q;
						tok_nxt.res_addr_lo = priv_addr_lo_q;
					end
				end
				FUNC_PRIV2PUB: begin
					if (priv_match) begin
						tok_nxt.found       = 1'b1;
						tok_nxt.res_family  = pub_family_q;
						tok_nxt.res_addr_hi = pub_addr_hi_q;
						tok_nxt.res_addr_lo = pub_addr_lo_q;
					end
				end
				default: ;
			endcase
		end
	end

	// entry storage, written once by the add that lands here
	always_ff @(posedge clk) begin
		if (write_en) begin
			pub_family_q   <= tok_in.item.key_family;
			pub_addr_hi_q  <= tok_in.item.key_addr_hi;
			pub_addr_lo_q  <= tok_in.item.key_addr_lo;
			priv_family_q  <= tok_in.item.val_family;
			priv_addr_hi_q <= tok_in.item.val_addr_hi;
			priv_addr_lo_q <= tok_in.item.val_addr_lo;
		end
	end

	// token valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_vld_q <= 1'b0;
		end else begin
			tok_vld_q <= tok_nxt.vld;
		end
	end

	// token payload
	always_ff @(posedge clk) begin
		tok_q <= tok_nxt;
	end

	// payload with the reset valid flag on top
	always_comb begin
		tok_out     = tok_q;
		tok_out.vld = tok_vld_q;
	end

endmodule

// ----- hdl/address_map_table_unit.sv -----
// top level of the address map table: cell row, entry counter, result register
// depends on amt_pkg, amt_cell and assert_macros.svh
//
// usage:
//   a transaction (request) is taken at a rising edge with start high and busy low.
//   func add stores a public/private pair in the next free entry; a lookup maps
//   public to private or private to public, lowest matching entry first.
//   each transaction gives exactly one result, shown on result for one cycle
//   with done high; the receiver cannot stall, so it must take it then.
//   the transaction walks the row of TABLE_DEPTH entry cells, one cell per
//   cycle, and a new one is not taken until the last is done; busy stays
//   high from the accepting edge until the edge that raises done, and a new
//   start may be given in the done cycle.
//   the entry counter is only advanced when an add leaves the row, so every
//   cell sees the same count during a walk.
//   reset (arst_n low) empties the table and drops any transaction in flight;
//   entry contents are not cleared, only the counter.
`include "assert_macros.svh"

module address_map_table_unit import amt_pkg::*; #(
	parameter int TABLE_DEPTH = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  in_item_t  request,
	output logic      done,
	output out_item_t result
);

	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	token_t           chain [TABLE_DEPTH+1];
	token_t           tail;
	logic [CNT_W-1:0] count_q;
	logic             busy_q;
	logic             done_q;
	out_item_t        result_q;
	out_item_t        result_nxt;
	logic             accept;
	logic             full;

	assign accept = start && !busy_q;
	assign full   = (count_q == CNT_W'(TABLE_DEPTH));

	// new transaction enters the head of the row
	always_comb begin
		chain[0]             = '0;
		chain[0].vld         = accept;
		chain[0].item        = request;
		chain[0].found       = 1'b0;
	end

	// row of entry cells
	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		amt_cell #(
			.CNT_W (CNT_W),
			.INDEX (i)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.count   (count_q),
			.tok_in  (chain[i]),
			.tok_out (chain[i+1])
		);
	end

	assign tail = chain[TABLE_DEPTH];

	// build the result from the token leaving the row
	always_comb begin
		result_nxt = '0;
		case (tail.item.func)
			FUNC_ADD: begin
				result_nxt.table_full = full;
			end
			FUNC_PUB2PRIV, FUNC_PRIV2PUB: begin
				result_nxt.out_port = tail.item.key_port;
				if (tail.found) begin
					result_nxt.out_family  = tail.res_family;
					result_nxt.out_addr_hi = tail.res_addr_hi;
					result_nxt.out_addr_lo = tail.res_addr_lo;
					result_nxt.hit         = 1'b1;
				end else begin
					result_nxt.out_family  = tail.item.key_family;
					result_nxt.out_addr_hi = tail.item.key_addr_hi;
					result_nxt.out_addr_lo = tail.item.key_addr_lo;
				end
			end
			default: ;
		endcase
	end

	// control: busy flag, done strobe, entry counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			count_q <= '0;
		end else begin
			done_q <= tail.vld;
			if (tail.vld)
				busy_q <= 1'b0;
			else if (accept)
				busy_q <= 1'b1;
			if (tail.vld && (tail.item.func == FUNC_ADD) && !full)
				count_q <= count_q + CNT_W'(1);
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (tail.vld)
			result_q <= result_nxt;
	end

	assign busy   = busy_q;
	assign done   = done_q;
	assign result = result_q;

	// checks
	`AMT_ASSERT_NEXT(a_accept_sets_busy, clk, arst_n, accept, busy, "accept did not raise busy")
	`AMT_ASSERT_NOW(a_done_not_busy, clk, arst_n, done, !busy, "done while still busy")
	`AMT_ASSERT_NOW(a_count_bound, clk, arst_n, 1'b1, count_q <= CNT_W'(TABLE_DEPTH), "count overflow")
	`AMT_ASSERT_NOW(a_hit_full_excl, clk, arst_n, done, !(result.hit && result.table_full), "hit and full together")

endmodule

// ----- dv/amt_result_check.sv -----
// result checker for the address map table: predicts each transaction's result and compares
// depends on amt_pkg; instantiated beside the block by tb_address_map_table_unit
module amt_result_check import amt_pkg::*; #(
	parameter int TABLE_DEPTH = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  logic      busy,
	input  in_item_t  request,
	input  logic      done,
	input  out_item_t result,
	output int        mismatch_count,
	output int        outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	// predicted table: public side in the key fields, private side in the val fields
	in_item_t    pair_store[TABLE_DEPTH];
	int unsigned pair_count;
	out_item_t   expected_translations[$];

	// family and address compare, port ignored
	function automatic logic addr_match(input logic [1:0] fam, input logic [63:0] hi,
		input logic [63:0] lo, input logic [1:0] sfam, input logic [63:0] shi,
		input logic [63:0] slo);
		if (fam != sfam)
			return 1'b0;
		if (fam == FAM_IPV4)
			return lo[31:0] == slo[31:0];
		if (fam == FAM_IPV6)
			return hi == shi && lo == slo;
		return 1'b0;
	endfunction

	// next result of the table, updating the predicted entries on an add
	function automatic out_item_t map_address(input in_item_t q);
		out_item_t r;
		in_item_t  e;
		logic      found;
		r = '0;
		found = 1'b0;
		case (q.func)
			FUNC_ADD: begin
				if (pair_count < TABLE_DEPTH) begin
					pair_store[pair_count] = q;
					pair_count++;
				end else begin
					r.table_full = 1'b1;
				end
			end
			FUNC_PUB2PRIV, FUNC_PRIV2PUB: begin
				for (int i = 0; i < pair_count && !found; i++) begin
					e = pair_store[i];
					if (q.func == FUNC_PUB2PRIV) begin
						if (addr_match(q.key_family, q.key_addr_hi, q.key_addr_lo,
							e.key_family, e.key_addr_hi, e.key_addr_lo)) begin
							found = 1'b1;
							r.out_family  = e.val_family;
							r.out_addr_hi = e.val_addr_hi;
							r.out_addr_lo = e.val_addr_lo;
						end
					end else if (addr_match(q.key_family, q.key_addr_hi, q.key_addr_lo,
						e.val_family, e.val_addr_hi, e.val_addr_lo)) begin
						found = 1'b1;
						r.out_family  = e.key_family;
						r.out_addr_hi = e.key_addr_hi;
						r.out_addr_lo = e.key_addr_lo;
					end
				end
				// a miss echoes the query
				if (!found) begin
					r.out_family  = q.key_family;
					r.out_addr_hi = q.key_addr_hi;
					r.out_addr_lo = q.key_addr_lo;
				end
				r.out_port = q.key_port;
				r.hit      = found;
			end
			default: ;
		endcase
		return r;
	endfunction

	// field by field compare against the oldest prediction
	task automatic compare_result(input out_item_t exp_r, input out_item_t got);
		if (got.out_family !== exp_r.out_family) begin
			$error("out_family: expected %0d, got %0d", exp_r.out_family, got.out_family);
			mismatch_count++;
		end
		if (got.out_addr_hi !== exp_r.out_addr_hi) begin
			$error("out_addr_hi: expected %h, got %h", exp_r.out_addr_hi, got.out_addr_hi);
			mismatch_count++;
		end
		if (got.out_addr_lo !== exp_r.out_addr_lo) begin
			$error("out_addr_lo: expected %h, got %h", exp_r.out_addr_lo, got.out_addr_lo);
			mismatch_count++;
		end
		if (got.out_port !== exp_r.out_port) begin
			$error("out_port: expected %0d, got %0d", exp_r.out_port, got.out_port);
			mismatch_count++;
		end
		if (got.hit !== exp_r.hit) begin
			$error("hit: expected %0d, got %0d", exp_r.hit, got.hit);
			mismatch_count++;
		end
		if (got.table_full !== exp_r.table_full) begin
			$error("table_full: expected %0d, got %0d", exp_r.table_full, got.table_full);
			mismatch_count++;
		end
	endtask

	initial mismatch_count = 0;

	// watch both channels at the rising edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_count = 0;
			expected_translations.delete();
			outstanding = 0;
		end else begin
			if (done === 1'b1) begin
				if (expected_translations.size() == 0) begin
					$error("result with no transaction pending");
					mismatch_count++;
				end else begin
					compare_result(expected_translations.pop_front(), result);
				end
			end
			if (start === 1'b1 && busy === 1'b0)
				expected_translations.push_back(map_address(request));
			outstanding = expected_translations.size();
		end
	end

endmodule

// ----- dv/tb_address_map_table_unit.sv -----
// testbench top for address_map_table_unit: clock, reset, directed and random stimulus
// depends on amt_pkg, address_map_table_unit and amt_result_check
module tb_address_map_table_unit import amt_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TABLE_DEPTH = 16;
	localparam int RANDOM_ITEMS = 1700;
	localparam int CYCLE_LIMIT = 500000;
	localparam logic [1:0] FAM_UNSPEC = 2'd2;
	localparam logic [1:0] FAM_RSVD   = 2'd3;

	logic      clk;
	logic      arst_n;
	logic      start;
	logic      busy;
	in_item_t  request;
	logic      done;
	out_item_t result;
	int        mismatch_count;
	int        outstanding;
	int        cycle_count;

	// every add sent, so lookups can aim at stored addresses
	in_item_t pairs_sent[$];

	address_map_table_unit #(.TABLE_DEPTH(TABLE_DEPTH)) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.request(request),
		.done   (done),
		.result (result)
	);

	amt_result_check #(.TABLE_DEPTH(TABLE_DEPTH)) i_result_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.request       (request),
		.done          (done),
		.result        (result),
		.mismatch_count(mismatch_count),
		.outstanding   (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// mostly real families, now and then unspecified or the unused code
	function automatic logic [1:0] pick_family();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return FAM_IPV4;
		if (r < 90)
			return FAM_IPV6;
		if (r < 95)
			return FAM_UNSPEC;
		return FAM_RSVD;
	endfunction

	function automatic in_item_t mk(input logic [1:0] func, input logic [1:0] kf,
		input logic [63:0] khi, input logic [63:0] klo, input logic [15:0] kport,
		input logic [1:0] vf, input logic [63:0] vhi, input logic [63:0] vlo);
		in_item_t q;
		q.func        = func;
		q.key_family  = kf;
		q.key_addr_hi = khi;
		q.key_addr_lo = klo;
		q.key_port    = kport;
		q.val_family  = vf;
		q.val_addr_hi = vhi;
		q.val_addr_lo = vlo;
		return q;
	endfunction

	function automatic in_item_t make_random(input logic [1:0] func);
		return mk(func, pick_family(), rand64(), rand64(), 16'($urandom),
			pick_family(), rand64(), rand64());
	endfunction

	// add with random content, sometimes reusing a stored address to test priority
	function automatic in_item_t make_add();
		in_item_t q;
		in_item_t p;
		int       r;
		q = make_random(FUNC_ADD);
		r = $urandom_range(0, 99);
		if (pairs_sent.size() != 0 && r < 30) begin
			p = pairs_sent[$urandom_range(0, pairs_sent.size() - 1)];
			if (r < 20) begin
				q.key_family  = p.key_family;
				q.key_addr_hi = p.key_addr_hi;
				q.key_addr_lo = p.key_addr_lo;
			end else begin
				q.val_family  = p.val_family;
				q.val_addr_hi = p.val_addr_hi;
				q.val_addr_lo = p.val_addr_lo;
			end
		end
		return q;
	endfunction

	// lookup: mostly a stored address, some on the wrong side, some one bit off
	function automatic in_item_t make_lookup();
		in_item_t     q;
		in_item_t     p;
		int           r;
		int           idx;
		logic         use_pub;
		logic [127:0] a;
		q = make_random($urandom_range(0, 1) ? FUNC_PUB2PRIV : FUNC_PRIV2PUB);
		r = $urandom_range(0, 99);
		if (pairs_sent.size() != 0 && r < 80) begin
			p = pairs_sent[$urandom_range(0, pairs_sent.size() - 1)];
			use_pub = (q.func == FUNC_PUB2PRIV) ^ (r >= 62);
			if (use_pub) begin
				q.key_family  = p.key_family;
				q.key_addr_hi = p.key_addr_hi;
				q.key_addr_lo = p.key_addr_lo;
			end else begin
				q.key_family  = p.val_family;
				q.key_addr_hi = p.val_addr_hi;
				q.key_addr_lo = p.val_addr_lo;
			end
			// ipv4 ignores the upper bits, so scramble them half the time
			if (q.key_family == FAM_IPV4 && $urandom_range(0, 1)) begin
				q.key_addr_hi        = rand64();
				q.key_addr_lo[63:32] = $urandom;
			end
			// near miss
			if (r >= 72) begin
				if (q.key_family == FAM_IPV4) begin
					idx = $urandom_range(0, 31);
				end else begin
					idx = $urandom_range(0, 127);
				end
				a = {q.key_addr_hi, q.key_addr_lo};
				a[idx] = ~a[idx];
				{q.key_addr_hi, q.key_addr_lo} = a;
			end
		end
		return q;
	endfunction

	// drive one transaction and hold it until the block takes it
	task automatic issue(input in_item_t q);
		@(negedge clk);
		start   <= 1'b1;
		request <= q;
		if (q.func == FUNC_ADD)
			pairs_sent.push_back(q);
		forever begin
			@(posedge clk);
			if (!busy)
				break;
		end
	endtask

	task automatic idle(input int n);
		repeat (n) begin
			@(negedge clk);
			start <= 1'b0;
		end
	endtask

	// stop sending until every predicted result has come back
	task automatic drain();
		idle(1);
		while (outstanding != 0)
			@(negedge clk);
	endtask

	initial begin
		int burst_left;
		int r;

		arst_n  = 1'b0;
		start   = 1'b0;
		request = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: empty table, unused code, then a small table with tricky entries
		issue(mk(FUNC_PUB2PRIV, FAM_IPV4, '1, '1, 16'hffff, FAM_RSVD, '1, '1));
		issue(mk(FUNC_NONE, FAM_RSVD, '1, '1, 16'hffff, FAM_RSVD, '1, '1));
		issue(mk(FUNC_ADD, FAM_IPV4, '1, 64'hffff_ffff_c0a8_0001, 16'h1234,
			FAM_IPV6, '1, '1));
		issue(mk(FUNC_ADD, FAM_IPV6, '0, '0, 16'h0000, FAM_IPV4, 64'h5a5a_5a5a_5a5a_5a5a,
			64'h0000_0000_ffff_ffff));
		issue(mk(FUNC_ADD, FAM_UNSPEC, 64'h1111, 64'h2222, 16'hffff, FAM_RSVD, 64'h3333,
			64'h4444));
		issue(mk(FUNC_ADD, FAM_IPV4, '0, 64'h0000_0000_c0a8_0001, 16'h0,
			FAM_IPV6, 64'h2001_0db8_0000_0000, 64'h1));
		issue(mk(FUNC_ADD, FAM_IPV6, '1, '1, 16'h8000, FAM_IPV4, '0, '0));
		// ipv4 hit with junk upper bits; lowest entry wins over the duplicate
		issue(mk(FUNC_PUB2PRIV, FAM_IPV4, 64'hdead_beef, 64'h1234_5678_c0a8_0001, 16'h0,
			FAM_IPV4, '0, '0));
		issue(mk(FUNC_PRIV2PUB, FAM_IPV6, '1, '1, 16'hffff, FAM_IPV4, '0, '0));
		issue(mk(FUNC_PUB2PRIV, FAM_IPV6, '0, '0, 16'h00ff, FAM_IPV4, '0, '0));
		issue(mk(FUNC_PUB2PRIV, FAM_IPV4, '0, '0, 16'h0101, FAM_IPV4, '0, '0));
		// unspecified and unused families never match
		issue(mk(FUNC_PUB2PRIV, FAM_UNSPEC, 64'h1111, 64'h2222, 16'h7fff, FAM_IPV4, '0, '0));
		issue(mk(FUNC_PRIV2PUB, FAM_RSVD, 64'h3333, 64'h4444, 16'h0001, FAM_IPV4, '0, '0));
		issue(mk(FUNC_PRIV2PUB, FAM_IPV4, '1, 64'h8000_0000_ffff_ffff, 16'hfffe,
			FAM_IPV4, '0, '0));
		issue(mk(FUNC_PRIV2PUB, FAM_IPV4, '0, '0, 16'h4000, FAM_IPV4, '0, '0));
		issue(mk(FUNC_PRIV2PUB, FAM_IPV6, 64'h2001_0db8_0000_0000, 64'h3, 16'h2222,
			FAM_IPV4, '0, '0));
		issue(mk(FUNC_PRIV2PUB, FAM_IPV6, 64'h2001_0db8_0000_0000, 64'h1, 16'h3333,
			FAM_IPV4, '0, '0));
		issue(mk(FUNC_NONE, FAM_IPV4, '0, '0, 16'h0, FAM_IPV4, '0, '0));
		drain();

		// random: bursts with gaps, the table filling and then overflowing on the way
		burst_left = 0;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 400 == 399)
				drain();
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 24);
				if ($urandom_range(0, 3) != 0)
					idle($urandom_range(1, 40));
			end
			burst_left--;
			r = $urandom_range(0, 99);
			if (r < 3)
				issue(make_add());
			else if (r < 5)
				issue(make_random(FUNC_NONE));
			else
				issue(make_lookup());
		end

		drain();
		repeat (TABLE_DEPTH + 4) @(negedge clk);
		if (mismatch_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
